// ----- hdl/aie_pkg.sv -----
// ----------------------------------------------------------------------------
// aie_pkg
// shared types, command and status codes for the accumulator instruction executor
// ----------------------------------------------------------------------------
package aie_pkg;

	localparam int NUM_VARIABLES = 26;
	localparam int DATA_WIDTH    = 32;
	localparam int VAR_AW        = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

	// command codes
	localparam logic [3:0] CMD_CLEAR = 4'd0;
	localparam logic [3:0] CMD_LOAD  = 4'd1;
	localparam logic [3:0] CMD_STORE = 4'd2;
	localparam logic [3:0] CMD_ADD   = 4'd3;
	localparam logic [3:0] CMD_SUB   = 4'd4;
	localparam logic [3:0] CMD_MUL   = 4'd5;
	localparam logic [3:0] CMD_DIV   = 4'd6;
	localparam logic [3:0] CMD_READ  = 4'd7;
	localparam logic [3:0] CMD_WRITE = 4'd8;
	localparam logic [3:0] CMD_HALT  = 4'd9;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_DIVZERO = 2'd1;
	localparam logic [1:0] STAT_HALTED  = 2'd2;
	localparam logic [1:0] STAT_UNSET   = 2'd3;

	typedef struct packed {
		logic [3:0]         cmd;
		logic               operand_is_variable;
		logic [13:0]        immediate;
		logic [4:0]         variable_index;
		logic signed [31:0] read_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] accumulator_out;
		logic               write_valid;
		logic signed [31:0] write_value;
		logic [1:0]         status;
		logic               halted_out;
	} rsp_t;

	// control from the sequencer to the shared arithmetic unit
	typedef struct packed {
		logic start;
		logic is_div;
	} alu_ctl_t;

	typedef struct packed {
		logic                  done;
		logic [DATA_WIDTH-1:0] result;
	} alu_rsp_t;

endpackage

// ----- hdl/aie_ram.sv -----
// ----------------------------------------------------------------------------
// aie_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module aie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 26,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/aie_alu.sv -----
// ----------------------------------------------------------------------------
// aie_alu
// shared shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
module aie_alu (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aie_pkg::alu_ctl_t                   ctl,
	input  logic [aie_pkg::DATA_WIDTH-1:0]      a,
	input  logic [aie_pkg::DATA_WIDTH-1:0]      b,
	output aie_pkg::alu_rsp_t                   rsp
);

	localparam int DW = aie_pkg::DATA_WIDTH;
	localparam int CW = $clog2(DW);

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_RUN,
		ALU_FIX
	} alu_state_t;

	alu_state_t      state_q;
	logic [CW-1:0]   cnt_q;
	logic            is_div_q;
	logic            neg_q;
	logic [DW-1:0]   p_q;
	logic [DW-1:0]   q_q;
	logic [DW-1:0]   m_q;
	logic            done_q;
	logic [DW-1:0]   result_q;

	logic [DW-1:0]   shifted_rem;
	logic [DW-1:0]   add_x;
	logic [DW-1:0]   add_y;
	logic [DW:0]     sum;
	logic [DW-1:0]   a_mag;
	logic [DW-1:0]   b_mag;

	// one adder serves both: accumulate for mul, trial subtract for div
	always_comb begin
		shifted_rem = {p_q[DW-2:0], q_q[DW-1]};
		add_x       = is_div_q ? shifted_rem : p_q;
		add_y       = is_div_q ? ~m_q : m_q;
		sum         = {1'b0, add_x} + {1'b0, add_y} + (DW+1)'(is_div_q);
		a_mag       = a[DW-1] ? (~a + DW'(1)) : a;
		b_mag       = b[DW-1] ? (~b + DW'(1)) : b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ALU_IDLE: begin
					if (ctl.start) begin
						is_div_q <= ctl.is_div;
						neg_q    <= a[DW-1] ^ b[DW-1];
						p_q      <= '0;
						q_q      <= ctl.is_div ? a_mag : b;
						m_q      <= ctl.is_div ? b_mag : a;
						cnt_q    <= CW'(DW - 1);
						state_q  <= ALU_RUN;
					end
				end
				ALU_RUN: begin
					if (is_div_q) begin
						if (sum[DW]) begin
							p_q <= sum[DW-1:0];
							q_q <= {q_q[DW-2:0], 1'b1};
						end else begin
							p_q <= shifted_rem;
							q_q <= {q_q[DW-2:0], 1'b0};
						end
					end else begin
						if (q_q[0]) begin
							p_q <= sum[DW-1:0];
						end
						m_q <= {m_q[DW-2:0], 1'b0};
						q_q <= {1'b0, q_q[DW-1:1]};
					end
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= ALU_FIX;
					end
				end
				ALU_FIX: begin
					// quotient sign fix, min / -1 wraps naturally
					if (is_div_q) begin
						result_q <= neg_q ? (~q_q + DW'(1)) : q_q;
					end else begin
						result_q <= p_q;
					end
					done_q  <= 1'b1;
					state_q <= ALU_IDLE;
				end
				default: begin
					state_q <= ALU_IDLE;
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

// ----- hdl/accumulator_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// accumulator_instruction_executor
// executes one decoded instruction of a small accumulator machine per request
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall / req_data carry one decoded
//   instruction; it is taken at a rising edge with req_valid high and
//   req_stall low
//   response channel: rsp_valid / rsp_stall / rsp_data return exactly one
//   result per request, in order; rsp_data holds while a valid response is stalled
//   sequence: clear, load, store, add, sub, read, write, halt and ignored
//   requests pass from fetch to done and into the output register; mul and
//   div that start the shared shift-add / restoring divide unit wait in busy
//   while it retires one bit per cycle, then a fix step with the quotient sign
//   throughput: one request in flight; req_stall is low only while the
//   sequencer is idle, so a new request is taken while the previous
//   response still waits in the output register
//   a stalled receiver holds the finished result in the sequencer until
//   the output register frees up
//   reset: accumulator zero, halted clear, all variable set marks clear;
//   no clearing pass, variable values are only read once marked set
// ----------------------------------------------------------------------------
module accumulator_instruction_executor (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  aie_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output aie_pkg::rsp_t rsp_data
);

	localparam int DW = aie_pkg::DATA_WIDTH;
	localparam int NV = aie_pkg::NUM_VARIABLES;
	localparam int AW = aie_pkg::VAR_AW;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_FETCH,
		SEQ_BUSY,
		SEQ_DONE
	} seq_state_t;

	seq_state_t        state_q;
	aie_pkg::req_t     req_q;
	logic [DW-1:0]     acc_q;
	logic              halted_q;
	logic [NV-1:0]     set_q;
	logic [1:0]        status_q;
	logic              wvalid_q;
	logic [31:0]       wvalue_q;
	logic              rsp_valid_q;
	aie_pkg::rsp_t     rsp_q;
	logic              rsp_load;

	// variable store
	logic [AW-1:0]     ram_raddr;
	logic [AW-1:0]     var_addr;
	logic [DW-1:0]     ram_rdata;
	logic              ram_we;
	logic [DW-1:0]     ram_wdata;

	// shared arithmetic unit
	aie_pkg::alu_ctl_t alu_ctl;
	aie_pkg::alu_rsp_t alu_rsp;

	// execute stage results
	logic              in_range;
	logic              have_opnd;
	logic [DW-1:0]     opnd;
	logic [DW-1:0]     ex_acc;
	logic              ex_halted;
	logic [1:0]        ex_status;
	logic              ex_wvalid;
	logic [31:0]       ex_wvalue;
	logic              ex_set;

	assign req_stall = (state_q != SEQ_IDLE);
	assign ram_raddr = AW'(req_data.variable_index);
	assign var_addr  = AW'(req_q.variable_index);

	// finished result moves into the output register this cycle
	assign rsp_load  = (state_q == SEQ_DONE) && (!rsp_valid_q || !rsp_stall);

	aie_ram #(
		.WIDTH (DW),
		.DEPTH (NV),
		.AW    (AW)
	) u_var_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (var_addr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	aie_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (acc_q),
		.b      (opnd),
		.rsp    (alu_rsp)
	);

	// decode and execute, valid in the fetch cycle when the ram data has landed
	always_comb begin
		in_range  = (int'(req_q.variable_index) < NV);
		have_opnd = !req_q.operand_is_variable || (in_range && set_q[var_addr]);
		opnd      = req_q.operand_is_variable ? ram_rdata : DW'(req_q.immediate);

		ex_acc        = acc_q;
		ex_halted     = halted_q;
		ex_status     = aie_pkg::STAT_OK;
		ex_wvalid     = 1'b0;
		ex_wvalue     = '0;
		ex_set        = 1'b0;
		ram_wdata     = (req_q.cmd == aie_pkg::CMD_STORE) ? acc_q : DW'(req_q.read_value);
		alu_ctl.start  = 1'b0;
		alu_ctl.is_div = (req_q.cmd == aie_pkg::CMD_DIV);

		if (req_q.cmd == aie_pkg::CMD_CLEAR) begin
			// clear also wakes a halted machine
			ex_acc    = '0;
			ex_halted = 1'b0;
		end else if (halted_q) begin
			ex_status = aie_pkg::STAT_HALTED;
		end else begin
			unique case (req_q.cmd) inside
				aie_pkg::CMD_HALT: begin
					ex_halted = 1'b1;
				end
				aie_pkg::CMD_STORE, aie_pkg::CMD_READ: begin
					// immediate target: nothing to write
					if (req_q.operand_is_variable) begin
						if (in_range) begin
							ex_set = 1'b1;
						end else begin
							ex_status = aie_pkg::STAT_UNSET;
						end
					end
				end
				aie_pkg::CMD_LOAD, aie_pkg::CMD_ADD, aie_pkg::CMD_SUB,
				aie_pkg::CMD_MUL, aie_pkg::CMD_DIV, aie_pkg::CMD_WRITE: begin
					if (!have_opnd) begin
						ex_status = aie_pkg::STAT_UNSET;
					end else begin
						unique case (req_q.cmd)
							aie_pkg::CMD_LOAD:  ex_acc = opnd;
							aie_pkg::CMD_ADD:   ex_acc = acc_q + opnd;
							aie_pkg::CMD_SUB:   ex_acc = acc_q - opnd;
							aie_pkg::CMD_MUL:   alu_ctl.start = (state_q == SEQ_FETCH);
							aie_pkg::CMD_DIV: begin
								if (opnd == '0) begin
									ex_status = aie_pkg::STAT_DIVZERO;
								end else begin
									alu_ctl.start = (state_q == SEQ_FETCH);
								end
							end
							default: begin
								ex_wvalid = 1'b1;
								ex_wvalue = 32'($signed(opnd));
							end
						endcase
					end
				end
				default: begin
					// unused command codes do nothing
				end
			endcase
		end

		ram_we = (state_q == SEQ_FETCH) && ex_set;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			acc_q       <= '0;
			halted_q    <= 1'b0;
			set_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				SEQ_IDLE: begin
					if (req_valid) begin
						req_q   <= req_data;
						state_q <= SEQ_FETCH;
					end
				end
				SEQ_FETCH: begin
					acc_q    <= ex_acc;
					halted_q <= ex_halted;
					status_q <= ex_status;
					wvalid_q <= ex_wvalid;
					wvalue_q <= ex_wvalue;
					if (ex_set) begin
						set_q[var_addr] <= 1'b1;
					end
					state_q <= alu_ctl.start ? SEQ_BUSY : SEQ_DONE;
				end
				SEQ_BUSY: begin
					if (alu_rsp.done) begin
						acc_q   <= alu_rsp.result;
						state_q <= SEQ_DONE;
					end
				end
				SEQ_DONE: begin
					// hand over once the output register is free
					if (rsp_load) begin
						rsp_q.accumulator_out <= 32'($signed(acc_q));
						rsp_q.write_valid     <= wvalid_q;
						rsp_q.write_value     <= wvalue_q;
						rsp_q.status          <= status_q;
						rsp_q.halted_out      <= halted_q;
						state_q               <= SEQ_IDLE;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ----- hdl/aie_checker.sv -----
// ----------------------------------------------------------------------------
// aie_checker
// port level checks for the accumulator instruction executor
// ----------------------------------------------------------------------------
module aie_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input aie_pkg::rsp_t rsp_data
);

	// a stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp_data))
		else $error("response changed while stalled");

	// one request at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

	a_ignored_halted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == aie_pkg::STAT_HALTED) |-> rsp_data.halted_out)
		else $error("ignored request without halted flag");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.write_valid |-> (rsp_data.write_value == '0))
		else $error("write value without write valid");

endmodule

bind accumulator_instruction_executor aie_checker u_aie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
